@@ rtl/rrtw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rrtw_pkg
// Shared types, sizes and codes of the round-robin task waker.
// ----------------------------------------------------------------------------
package rrtw_pkg;

    localparam int MAX_TASKS = 8;
    localparam int TICK_BITS = 32;

    localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int ADDR_W = 5;
    localparam int MASK_W = 8;

    typedef logic [TICK_BITS-1:0] tick_t;

    typedef enum logic [2:0] {
        OP_SELECT = 3'd0,
        OP_HALTED = 3'd1,
        OP_DELAY  = 3'd2,
        OP_SLEEP  = 3'd3,
        OP_WAKE   = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        REG_TASK_COUNT = 3'd0,
        REG_SETUP_MASK = 3'd1,
        REG_LOOP_MASK  = 3'd2,
        REG_CRASH_MASK = 3'd3,
        REG_HALT_TMO   = 3'd4
    } reg_index_t;

    localparam logic [1:0] PHASE_SETUP = 2'd0;
    localparam logic [1:0] PHASE_LOOP  = 2'd1;
    localparam logic [1:0] PHASE_CRASH = 2'd2;

    localparam logic [1:0] MODE_AWAKE = 2'd0;
    localparam logic [1:0] MODE_DELAY = 2'd1;
    localparam logic [1:0] MODE_SLEEP = 2'd2;

    localparam logic [1:0] ROUTINE_SETUP = 2'd0;
    localparam logic [1:0] ROUTINE_LOOP  = 2'd1;
    localparam logic [1:0] ROUTINE_CRASH = 2'd2;

    // writes into one cell, decoded from an accepted item
    typedef struct packed {
        logic wr_delay;
        logic wr_sleep;
        logic wr_wake;
        logic wr_crash;
    } cell_cmd_t;

    // routine presence bits of one task
    typedef struct packed {
        logic setup;
        logic loop;
        logic crash;
    } cell_mask_t;

    // report of the cell that holds the scan token
    typedef struct packed {
        logic       hit;
        logic [1:0] routine;
        logic       present;
    } cell_rpt_t;

endpackage
`default_nettype wire

@@ rtl/rrtw_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rrtw_cell
// One task slot: life phase, sleep mode, wake time and the scan token.
// ----------------------------------------------------------------------------
module rrtw_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rrtw_pkg::cell_cmd_t cmd,
    input  wire rrtw_pkg::tick_t    wake_value,
    input  wire rrtw_pkg::tick_t    scan_now,
    input  wire rrtw_pkg::cell_mask_t mask,
    input  wire logic               tok_load,
    input  wire logic               tok_in,
    input  wire logic               tok_cont,
    output logic                    tok,
    output rrtw_pkg::cell_rpt_t     rpt
);

    logic [1:0]      phase_reg;
    logic [1:0]      phase_next;
    logic [1:0]      mode_reg;
    logic [1:0]      mode_next;
    logic            tok_reg;
    logic            tok_next;
    rrtw_pkg::tick_t wake_time_reg;
    rrtw_pkg::tick_t diff;
    logic            expired;
    logic            hit;

    always_comb
    begin
        diff    = scan_now - wake_time_reg;
        // wrap-safe: passed when the difference is non-negative
        expired = (mode_reg == rrtw_pkg::MODE_DELAY) && !diff[rrtw_pkg::TICK_BITS-1];
        hit     = tok_reg && ((mode_reg == rrtw_pkg::MODE_AWAKE) || expired);
    end

    always_comb
    begin
        phase_next = phase_reg;
        mode_next  = mode_reg;
        rpt        = '0;
        if (cmd.wr_crash)
        begin
            phase_next = rrtw_pkg::PHASE_CRASH;
        end
        if (cmd.wr_delay)
        begin
            mode_next = rrtw_pkg::MODE_DELAY;
        end
        if (cmd.wr_sleep)
        begin
            mode_next = rrtw_pkg::MODE_SLEEP;
        end
        if (cmd.wr_wake)
        begin
            mode_next = rrtw_pkg::MODE_AWAKE;
        end
        if (hit)
        begin
            mode_next = rrtw_pkg::MODE_AWAKE;
            rpt.hit   = 1'b1;
            case (phase_reg)
                rrtw_pkg::PHASE_LOOP:
                begin
                    rpt.routine = rrtw_pkg::ROUTINE_LOOP;
                    rpt.present = mask.loop;
                end
                rrtw_pkg::PHASE_CRASH:
                begin
                    rpt.routine = rrtw_pkg::ROUTINE_CRASH;
                    rpt.present = mask.crash;
                    phase_next  = rrtw_pkg::PHASE_SETUP;
                end
                default:
                begin
                    rpt.routine = rrtw_pkg::ROUTINE_SETUP;
                    rpt.present = mask.setup;
                    phase_next  = rrtw_pkg::PHASE_LOOP;
                end
            endcase
        end
        // hand the token on, or drop it when the scan ends
        tok_next = tok_load || (tok_in && tok_cont);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rrtw_pkg::PHASE_SETUP;
            mode_reg  <= rrtw_pkg::MODE_AWAKE;
            tok_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_delay)
        begin
            wake_time_reg <= wake_value;
        end
    end

    assign tok = tok_reg;

endmodule
`default_nettype wire

@@ rtl/round_robin_task_waker_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_task_waker_top
// Round-robin task picker: a ring of task cells passes a scan token.
// ----------------------------------------------------------------------------
// Timing: delay, sleep, wake and halt items show their result in the cycle after
// start; a select visits 1 to task count tasks (at most 8), one cell per cycle as
// the token moves down the ring; the result is registered on a hit or at the last task.
// Flow: busy is high while a select scans; a new item may start in the
// cycle its predecessor's result is shown. The receiver cannot stall.
// Reset: all tasks in setup and awake, pointer and last run zero, registers
// at their defaults; wake times hold no value until a delay writes them.
module round_robin_task_waker_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [2:0]                    opcode,
    input  wire logic [2:0]                    task_index,
    input  wire logic [31:0]                   delay_ticks,
    input  wire logic [31:0]                   now_tick,
    output logic                               done,
    output logic                               task_valid,
    output logic [2:0]                         task_id,
    output logic [1:0]                         routine,
    output logic                               routine_present,
    output logic [15:0]                        halt_deadline,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rrtw_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int N     = rrtw_pkg::MAX_TASKS;
    localparam int IDX_W = rrtw_pkg::IDX_W;
    localparam int CNT_W = rrtw_pkg::CNT_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration
    logic [3:0]  task_count_reg;
    logic [7:0]  setup_mask_reg;
    logic [7:0]  loop_mask_reg;
    logic [7:0]  crash_mask_reg;
    logic [15:0] halt_tmo_reg;
    logic        cfg_wr;

    // scan control
    logic [IDX_W-1:0] ptr_reg;
    logic [IDX_W-1:0] ptr_next;
    logic [IDX_W-1:0] cur_reg;
    logic [IDX_W-1:0] cur_next;
    logic [IDX_W-1:0] last_run_reg;
    logic [IDX_W-1:0] last_run_next;
    logic [CNT_W-1:0] step_reg;
    logic [CNT_W-1:0] step_next;
    rrtw_pkg::tick_t  now_reg;

    logic             accept;
    logic             is_select;
    logic             idx_ok;
    logic [CNT_W-1:0] n_act;
    logic [CNT_W-1:0] cur_plus;
    logic [IDX_W-1:0] cur_wrap;
    logic [IDX_W-1:0] start_idx;
    logic             scanning;
    logic             last_step;
    logic             tok_cont;
    rrtw_pkg::tick_t  wake_value;

    // ring
    rrtw_pkg::cell_cmd_t  cmd     [N];
    rrtw_pkg::cell_mask_t cmask   [N];
    rrtw_pkg::cell_rpt_t  rpt     [N];
    logic [N-1:0]         tok;
    logic [N-1:0]         tok_in;
    logic [N-1:0]         tok_load;
    logic [N-1:0]         last_act;
    rrtw_pkg::cell_rpt_t  rpt_any;

    // result
    logic        done_reg;
    logic        valid_reg;
    logic [2:0]  id_reg;
    logic [1:0]  routine_reg;
    logic        present_reg;
    logic [15:0] deadline_reg;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= 4'd1;
            setup_mask_reg <= 8'hFF;
            loop_mask_reg  <= 8'hFF;
            crash_mask_reg <= 8'hFF;
            halt_tmo_reg   <= 16'd1000;
        end
        else if (cfg_wr)
        begin
            case (rrtw_pkg::reg_index_t'(paddr[4:2]))
                rrtw_pkg::REG_TASK_COUNT: task_count_reg <= pwdata[3:0];
                rrtw_pkg::REG_SETUP_MASK: setup_mask_reg <= pwdata[7:0];
                rrtw_pkg::REG_LOOP_MASK:  loop_mask_reg  <= pwdata[7:0];
                rrtw_pkg::REG_CRASH_MASK: crash_mask_reg <= pwdata[7:0];
                rrtw_pkg::REG_HALT_TMO:   halt_tmo_reg   <= pwdata[15:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (rrtw_pkg::reg_index_t'(paddr[4:2]))
            rrtw_pkg::REG_TASK_COUNT: prdata = {28'd0, task_count_reg};
            rrtw_pkg::REG_SETUP_MASK: prdata = {24'd0, setup_mask_reg};
            rrtw_pkg::REG_LOOP_MASK:  prdata = {24'd0, loop_mask_reg};
            rrtw_pkg::REG_CRASH_MASK: prdata = {24'd0, crash_mask_reg};
            rrtw_pkg::REG_HALT_TMO:   prdata = {16'd0, halt_tmo_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // item decode and scan control
    // ------------------------------------------------------------------
    assign busy      = (state_reg == S_SCAN);
    assign scanning  = (state_reg == S_SCAN);
    assign accept    = start && !busy;
    assign is_select = (rrtw_pkg::opcode_t'(opcode) == rrtw_pkg::OP_SELECT);
    assign idx_ok    = (int'(task_index) < N);
    assign wake_value = rrtw_pkg::tick_t'(now_tick) + rrtw_pkg::tick_t'(delay_ticks);

    // count 0 acts as 1, above the ring size as the ring size
    always_comb
    begin
        if (task_count_reg == 4'd0)
        begin
            n_act = CNT_W'(1);
        end
        else if (int'(task_count_reg) > N)
        begin
            n_act = CNT_W'(N);
        end
        else
        begin
            n_act = CNT_W'(task_count_reg);
        end
    end

    assign start_idx = (CNT_W'(ptr_reg) >= n_act) ? '0 : ptr_reg;
    assign cur_plus  = CNT_W'(cur_reg) + CNT_W'(1);
    assign cur_wrap  = (cur_plus >= n_act) ? '0 : IDX_W'(cur_plus);
    assign last_step = (step_reg == n_act - CNT_W'(1));
    assign tok_cont  = scanning && !rpt_any.hit && !last_step;

    always_comb
    begin
        rpt_any = '0;
        for (int i = 0; i < N; i++)
        begin
            rpt_any = rpt_any | rpt[i];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        cur_next      = cur_reg;
        step_next     = step_reg;
        last_run_next = last_run_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && is_select)
                begin
                    state_next = S_SCAN;
                    cur_next   = start_idx;
                    step_next  = '0;
                end
            end
            S_SCAN:
            begin
                cur_next  = cur_wrap;
                step_next = step_reg + CNT_W'(1);
                if (rpt_any.hit)
                begin
                    state_next    = S_IDLE;
                    last_run_next = cur_reg;
                    ptr_next      = cur_wrap;
                end
                else if (last_step)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ptr_reg      <= '0;
            cur_reg      <= '0;
            step_reg     <= '0;
            last_run_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            cur_reg      <= cur_next;
            step_reg     <= step_next;
            last_run_reg <= last_run_next;
            done_reg     <= (accept && !is_select) ||
                            (scanning && (rpt_any.hit || last_step));
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_select)
        begin
            now_reg <= rrtw_pkg::tick_t'(now_tick);
        end
        if (scanning && rpt_any.hit)
        begin
            valid_reg    <= 1'b1;
            id_reg       <= 3'(cur_reg);
            routine_reg  <= rpt_any.routine;
            present_reg  <= rpt_any.present;
            deadline_reg <= rpt_any.present ? (now_reg[15:0] + halt_tmo_reg) : 16'd0;
        end
        else
        begin
            valid_reg    <= 1'b0;
            id_reg       <= 3'd0;
            routine_reg  <= rrtw_pkg::ROUTINE_SETUP;
            present_reg  <= 1'b0;
            deadline_reg <= 16'd0;
        end
    end

    // ------------------------------------------------------------------
    // ring of task cells
    // ------------------------------------------------------------------
    // the last active cell hands its token back to cell 0
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            last_act[i] = (CNT_W'(i) == n_act - CNT_W'(1));
        end
        tok_in[0] = |(tok & last_act);
        for (int i = 1; i < N; i++)
        begin
            tok_in[i] = tok[i-1] && !last_act[i-1];
        end
    end

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        assign tok_load[g]     = accept && is_select && (start_idx == IDX_W'(g));
        assign cmd[g].wr_delay = accept && idx_ok && (int'(task_index) == g) &&
                                 (rrtw_pkg::opcode_t'(opcode) == rrtw_pkg::OP_DELAY);
        assign cmd[g].wr_sleep = accept && idx_ok && (int'(task_index) == g) &&
                                 (rrtw_pkg::opcode_t'(opcode) == rrtw_pkg::OP_SLEEP);
        assign cmd[g].wr_wake  = accept && idx_ok && (int'(task_index) == g) &&
                                 (rrtw_pkg::opcode_t'(opcode) == rrtw_pkg::OP_WAKE);
        assign cmd[g].wr_crash = accept && (last_run_reg == IDX_W'(g)) &&
                                 (rrtw_pkg::opcode_t'(opcode) == rrtw_pkg::OP_HALTED);

        if (g < rrtw_pkg::MASK_W)
        begin : g_mask
            assign cmask[g].setup = setup_mask_reg[g];
            assign cmask[g].loop  = loop_mask_reg[g];
            assign cmask[g].crash = crash_mask_reg[g];
        end
        else
        begin : g_nomask
            assign cmask[g] = '0;
        end

        rrtw_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd[g]),
            .wake_value (wake_value),
            .scan_now   (now_reg),
            .mask       (cmask[g]),
            .tok_load   (tok_load[g]),
            .tok_in     (tok_in[g]),
            .tok_cont   (tok_cont),
            .tok        (tok[g]),
            .rpt        (rpt[g])
        );
    end

    assign done            = done_reg;
    assign task_valid      = valid_reg;
    assign task_id         = id_reg;
    assign routine         = routine_reg;
    assign routine_present = present_reg;
    assign halt_deadline   = deadline_reg;

endmodule
`default_nettype wire

@@ rtl/rrtw_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rrtw_checker
// Port-level checks of the round-robin task waker, bound to the top level.
// ----------------------------------------------------------------------------
module rrtw_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic        task_valid,
    input wire logic [2:0]  task_id,
    input wire logic [1:0]  routine,
    input wire logic        routine_present,
    input wire logic [15:0] halt_deadline
);

    // every accepted item either reports next cycle or starts a scan
    property p_accept_moves;
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy);
    endproperty
    a_accept_moves: assert property (p_accept_moves)
        else $error("accepted item neither reported nor scanning");

    // a scan always ends with a result
    property p_scan_ends_done;
        @(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done;
    endproperty
    a_scan_ends_done: assert property (p_scan_ends_done)
        else $error("scan ended without a result");

    // an empty result carries all fields zero
    property p_empty_zero;
        @(posedge clk) disable iff (!rst_n)
        (done && !task_valid) |-> (task_id == 3'd0 && routine == 2'd0 &&
                                   !routine_present && halt_deadline == 16'd0);
    endproperty
    a_empty_zero: assert property (p_empty_zero)
        else $error("empty result with nonzero fields");

    // a missing routine gets no deadline, and no routine code 3 is reported
    property p_routine_sane;
        @(posedge clk) disable iff (!rst_n)
        done |-> (routine != 2'd3 && (routine_present || halt_deadline == 16'd0));
    endproperty
    a_routine_sane: assert property (p_routine_sane)
        else $error("bad routine code or deadline without routine");

endmodule

bind round_robin_task_waker_top rrtw_checker u_rrtw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .task_valid      (task_valid),
    .task_id         (task_id),
    .routine         (routine),
    .routine_present (routine_present),
    .halt_deadline   (halt_deadline)
);
`default_nettype wire
